>>> design/lca_pkg.sv
// Shared types, constants and the life rule for the cellular automaton grid.
package lca_pkg;

  localparam int unsigned ROWS_DEF = 16;
  localparam int unsigned COLS_DEF = 32;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned ROW_W = 4;
  localparam int unsigned COL_W = 5;
  localparam int unsigned CNT_W = 4;

  localparam logic [CNT_W-1:0] BIRTH_CNT   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SURVIVE_CNT = CNT_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // Per-row-cell command for the current cycle.
  typedef struct packed {
    logic wr_en;
    logic step_en;
    logic cell_in;
  } cell_ctrl_t;

  // B3/S23: born with exactly three neighbors, survives with two or three.
  function automatic logic life_rule(input logic alive, input logic [CNT_W-1:0] cnt);
    return (cnt == BIRTH_CNT) || (alive && (cnt == SURVIVE_CNT));
  endfunction

endpackage

>>> design/lca_if.sv
// Command and result channel interfaces of the cellular automaton grid.
interface lca_cmd_if;
  import lca_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             cell_in;

  modport source (output valid, output opcode, output row, output col, output cell_in,
                  input ready);
  modport sink   (input valid, input opcode, input row, input col, input cell_in,
                  output ready);
endinterface

interface lca_res_if;
  logic valid;
  logic ready;
  logic cell_out;

  modport source (output valid, output cell_out, input ready);
  modport sink   (input valid, input cell_out, output ready);
endinterface

>>> design/lca_row_cell.sv
// One board row: holds its cells and computes its next generation from its neighbors.
module lca_row_cell #(
  parameter int unsigned COLS = lca_pkg::COLS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lca_pkg::cell_ctrl_t      ctrl_i,
  input  logic [lca_pkg::COL_W-1:0] col_i,
  input  logic [COLS-1:0]          up_i,
  input  logic [COLS-1:0]          dn_i,
  output logic [COLS-1:0]          row_o,
  output logic                     rd_bit_o
);
  import lca_pkg::*;

  logic [COLS-1:0]   row_q, row_d;
  logic [COLS-1:0]   col_hit;
  logic [COLS-1:0]   next_gen;
  logic [COLS+1:0]   pad_up, pad_mid, pad_dn;
  logic [CNT_W-1:0]  cnt;

  assign pad_up  = {1'b0, up_i, 1'b0};
  assign pad_mid = {1'b0, row_q, 1'b0};
  assign pad_dn  = {1'b0, dn_i, 1'b0};

  // Column c of the row sits at index c+1 of the padded vectors; the pad bits
  // stand for the dead cells beyond the left and right edges.
  always_comb begin
    next_gen = '0;
    col_hit  = '0;
    cnt      = '0;
    for (int c = 0; c < COLS; c++) begin
      col_hit[c] = (32'(col_i) == c);
      cnt = CNT_W'(pad_up[c]) + CNT_W'(pad_up[c+1]) + CNT_W'(pad_up[c+2])
          + CNT_W'(pad_mid[c]) + CNT_W'(pad_mid[c+2])
          + CNT_W'(pad_dn[c]) + CNT_W'(pad_dn[c+1]) + CNT_W'(pad_dn[c+2]);
      next_gen[c] = life_rule(row_q[c], cnt);
    end
  end

  always_comb begin
    row_d = row_q;
    if (ctrl_i.step_en) begin
      row_d = next_gen;
    end else if (ctrl_i.wr_en) begin
      row_d = (row_q & ~col_hit) | (col_hit & {COLS{ctrl_i.cell_in}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o    = row_q;
  assign rd_bit_o = |(row_q & col_hit);

endmodule

>>> design/life_cellular_automaton_grid_unit.sv
// Game of Life board (B3/S23) built as a chain of row cells, each holding one board row
// and exchanging it with the rows above and below every cycle. A write or an advance
// changes the board at the edge where it is accepted, and all rows compute their next
// generation in parallel, so the whole board advances at once for any board size. A read
// samples the board at its accept edge and its result appears in
// the output register on the next cycle. A new command is taken whenever that output
// register is empty or being drained, so the only wait comes from a stalled result.
// Cells beyond the board edges are dead; writes off the board are dropped and reads off
// the board return a dead cell. Reset clears the whole board at once.
module life_cellular_automaton_grid_unit #(
  parameter int unsigned ROWS = lca_pkg::ROWS_DEF,
  parameter int unsigned COLS = lca_pkg::COLS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lca_cmd_if.sink   cmd_i,
  lca_res_if.source res_o
);
  import lca_pkg::*;

  logic            cmd_acc;
  op_e             op;
  logic            out_valid_q, out_valid_d;
  logic            out_cell_q, out_cell_d;
  logic [ROWS-1:0] row_hit;
  logic [ROWS-1:0] rd_bits;
  logic            rd_bit;
  logic [COLS-1:0] rows_w [ROWS];
  cell_ctrl_t      ctrl   [ROWS];

  assign op          = op_e'(cmd_i.opcode);
  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  genvar r;
  generate
    for (r = 0; r < ROWS; r++) begin : g_row
      logic [COLS-1:0] up_row, dn_row;

      assign row_hit[r] = (32'(cmd_i.row) == r);

      if (r == 0) begin : g_top
        assign up_row = '0;
      end else begin : g_mid_up
        assign up_row = rows_w[r-1];
      end
      if (r == ROWS - 1) begin : g_bot
        assign dn_row = '0;
      end else begin : g_mid_dn
        assign dn_row = rows_w[r+1];
      end

      assign ctrl[r].wr_en   = cmd_acc && (op == OP_WRITE) && row_hit[r];
      assign ctrl[r].step_en = cmd_acc && (op == OP_STEP);
      assign ctrl[r].cell_in = cmd_i.cell_in;

      lca_row_cell #(
        .COLS(COLS)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl[r]),
        .col_i    (cmd_i.col),
        .up_i     (up_row),
        .dn_i     (dn_row),
        .row_o    (rows_w[r]),
        .rd_bit_o (rd_bits[r])
      );
    end
  endgenerate

  assign rd_bit = |(rd_bits & row_hit);

  always_comb begin
    out_valid_d = out_valid_q;
    out_cell_d  = out_cell_q;
    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_acc && (op == OP_READ)) begin
      out_valid_d = 1'b1;
      out_cell_d  = rd_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_cell_q <= out_cell_d;
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.cell_out = out_cell_q;

  // An accepted read always produces a result on the next cycle.
  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && (op == OP_READ)) |=> res_o.valid)
    else $error("accepted read did not produce a result");

  // A drained result is not repeated unless a new read was accepted.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && !(cmd_acc && (op == OP_READ))) |=> !res_o.valid)
    else $error("result repeated without a read");

  // A write on the board lands in the addressed cell.
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && (op == OP_WRITE) && (32'(cmd_i.row) < ROWS) && (32'(cmd_i.col) < COLS))
    |=> (rows_w[$past(cmd_i.row)][$past(cmd_i.col)] == $past(cmd_i.cell_in)))
    else $error("written cell does not hold the written value");

endmodule
